/* hdl/cte_pkg.sv */
`timescale 1ns / 1ps
package cte_pkg;

   // Field widths
   localparam int unsigned YEAR_W  = 8;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned HOUR_W  = 5;
   localparam int unsigned MIN_W   = 6;
   localparam int unsigned SEC_W   = 6;
   localparam int unsigned SECS_W  = 34;

   // Day count and time-of-day widths (largest day count is below 2^17)
   localparam int unsigned DAYS_W = 17;
   localparam int unsigned TOD_W  = 17;
   localparam int unsigned DBM_W  = 9;

   // Offset of the epoch year from 1900
   localparam logic [YEAR_W-1:0] UNIX_BASE_OFS = 8'd70;
   // Offset of 2100, a century year that is not a leap year
   localparam logic [YEAR_W-1:0] NONLEAP_CENTURY_OFS = 8'd200;

   localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;

   localparam logic [DAYS_W-1:0] DAYS_COMMON_YEAR = 17'd365;
   localparam logic [DAYS_W-1:0] DAYS_LEAP_YEAR   = 17'd366;

   localparam logic [TOD_W-1:0]  SECS_PER_HOUR   = 17'd3600;
   localparam logic [TOD_W-1:0]  SECS_PER_MINUTE = 17'd60;
   localparam logic [SECS_W-1:0] SECS_PER_DAY    = 34'd86400;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic year_step;
      logic add_month;
      logic mult;
      logic sum;
      logic finish;
   } cte_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic year_done;
      logic err;
   } cte_status_type;

   // Gregorian leap test on a year given as offset from 1900 (1900..2155)
   function automatic logic is_leap(input logic [YEAR_W-1:0] yofs);
      is_leap = (yofs[1:0] == 2'b00) && (yofs != NONLEAP_CENTURY_OFS) &&
                (yofs != '0);
   endfunction

   // Days before the first of a month (1..12); leap years gain a day from March
   function automatic logic [DBM_W-1:0] days_before_month(
      input logic                leap,
      input logic [MONTH_W-1:0] mon
   );
      logic [DBM_W-1:0] base;
      base = '0;
      unique case (mon)
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && (mon > MONTH_FEB)) begin
         base = base + 9'd1;
      end
      days_before_month = base;
   endfunction

endpackage

/* hdl/calendar_to_epoch_seconds.sv */
`timescale 1ns / 1ps
// Channel   Ports                                   Direction   Handshake
// req       year_since_1900 month day_of_month      in          req_valid / req_stall
//           hour minute second
// rsp       epoch_seconds error                     out         rsp_valid / rsp_stall
//
// An item walks the years from 1970 to its year, adding one whole year a cycle, then
// passes the month, multiply, sum and finish states. A faulted item skips to finish.
// One item is in work at a time; req_stall is high until the result is loaded.
// Reset is synchronous and clears the controller and the result valid.
// A stalled result is held while the next item is accepted and worked on.
module calendar_to_epoch_seconds (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cte_pkg::YEAR_W-1:0]    req_year_since_1900,
   input  logic [cte_pkg::MONTH_W-1:0]   req_month,
   input  logic [cte_pkg::DAY_W-1:0]     req_day_of_month,
   input  logic [cte_pkg::HOUR_W-1:0]    req_hour,
   input  logic [cte_pkg::MIN_W-1:0]     req_minute,
   input  logic [cte_pkg::SEC_W-1:0]     req_second,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cte_pkg::SECS_W-1:0]    rsp_epoch_seconds,
   output logic                          rsp_error
);

   cte_pkg::cte_cmd_type    cmd;
   cte_pkg::cte_status_type status;

   cte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   cte_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .year_since_1900 (req_year_since_1900),
      .month           (req_month),
      .day_of_month    (req_day_of_month),
      .hour            (req_hour),
      .minute          (req_minute),
      .second          (req_second),
      .epoch_seconds   (rsp_epoch_seconds),
      .error           (rsp_error)
   );

endmodule

/* hdl/cte_dp.sv */
`timescale 1ns / 1ps
module cte_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  cte_pkg::cte_cmd_type            cmd,
   output cte_pkg::cte_status_type         status,
   input  logic [cte_pkg::YEAR_W-1:0]      year_since_1900,
   input  logic [cte_pkg::MONTH_W-1:0]     month,
   input  logic [cte_pkg::DAY_W-1:0]       day_of_month,
   input  logic [cte_pkg::HOUR_W-1:0]      hour,
   input  logic [cte_pkg::MIN_W-1:0]       minute,
   input  logic [cte_pkg::SEC_W-1:0]       second,
   output logic [cte_pkg::SECS_W-1:0]      epoch_seconds,
   output logic                            error
);

   logic [cte_pkg::YEAR_W-1:0]  year_ff,  year_in;
   logic [cte_pkg::MONTH_W-1:0] month_ff, month_in;
   logic [cte_pkg::DAY_W-1:0]   day_ff,   day_in;
   logic [cte_pkg::HOUR_W-1:0]  hour_ff,  hour_in;
   logic [cte_pkg::MIN_W-1:0]   minute_ff, minute_in;
   logic [cte_pkg::SEC_W-1:0]   second_ff, second_in;
   logic                        err_ff,   err_in;
   logic [cte_pkg::YEAR_W-1:0]  ycnt_ff,  ycnt_in;
   logic [cte_pkg::DAYS_W-1:0]  days_ff,  days_in;
   logic [cte_pkg::TOD_W-1:0]   tod_ff,   tod_in;
   logic [cte_pkg::SECS_W-1:0]  prod_ff,  prod_in;
   logic [cte_pkg::SECS_W-1:0]  secs_ff,  secs_in;
   logic [cte_pkg::SECS_W-1:0]  out_secs_ff, out_secs_in;
   logic                        out_err_ff,  out_err_in;

   logic                        bad_input;
   logic [cte_pkg::DBM_W-1:0]   dbm;

   // Range check of year and month on the incoming item
   assign bad_input = (year_since_1900 < cte_pkg::UNIX_BASE_OFS) ||
                      (month < cte_pkg::MONTH_FIRST) || (month > cte_pkg::MONTH_LAST);

   // Month table, leap test on the full year
   assign dbm = cte_pkg::days_before_month(cte_pkg::is_leap(year_ff), month_ff);

   always_comb begin
      year_in     = year_ff;
      month_in    = month_ff;
      day_in      = day_ff;
      hour_in     = hour_ff;
      minute_in   = minute_ff;
      second_in   = second_ff;
      err_in      = err_ff;
      ycnt_in     = ycnt_ff;
      days_in     = days_ff;
      tod_in      = tod_ff;
      prod_in     = prod_ff;
      secs_in     = secs_ff;
      out_secs_in = out_secs_ff;
      out_err_in  = out_err_ff;

      // Capture the item and start the year walk at 1970
      if (cmd.load) begin
         year_in   = year_since_1900;
         month_in  = month;
         day_in    = day_of_month;
         hour_in   = hour;
         minute_in = minute;
         second_in = second;
         err_in    = bad_input;
         ycnt_in   = cte_pkg::UNIX_BASE_OFS;
         days_in   = '0;
      end

      // Add one whole year
      if (cmd.year_step) begin
         days_in = days_ff + (cte_pkg::is_leap(ycnt_ff) ? cte_pkg::DAYS_LEAP_YEAR
                                                        : cte_pkg::DAYS_COMMON_YEAR);
         ycnt_in = ycnt_ff + 8'd1;
      end

      // Add days before the month and the day itself; form the time of day
      if (cmd.add_month) begin
         days_in = days_ff + cte_pkg::DAYS_W'(dbm) + cte_pkg::DAYS_W'(day_ff);
         tod_in  = cte_pkg::TOD_W'(hour_ff) * cte_pkg::SECS_PER_HOUR +
                   cte_pkg::TOD_W'(minute_ff) * cte_pkg::SECS_PER_MINUTE +
                   cte_pkg::TOD_W'(second_ff);
      end

      // Scale days to seconds
      if (cmd.mult) begin
         prod_in = cte_pkg::SECS_W'(days_ff) * cte_pkg::SECS_PER_DAY;
      end

      // Add time of day; the day count was one-based, so drop one day
      if (cmd.sum) begin
         secs_in = prod_ff + cte_pkg::SECS_W'(tod_ff) - cte_pkg::SECS_PER_DAY;
      end

      // Load the output register
      if (cmd.finish) begin
         out_secs_in = err_ff ? '0 : secs_ff;
         out_err_in  = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      year_ff     <= year_in;
      month_ff    <= month_in;
      day_ff      <= day_in;
      hour_ff     <= hour_in;
      minute_ff   <= minute_in;
      second_ff   <= second_in;
      err_ff      <= err_in;
      ycnt_ff     <= ycnt_in;
      days_ff     <= days_in;
      tod_ff      <= tod_in;
      prod_ff     <= prod_in;
      secs_ff     <= secs_in;
      out_secs_ff <= out_secs_in;
      out_err_ff  <= out_err_in;
   end

   assign status.year_done = (ycnt_ff == year_ff);
   assign status.err       = err_ff;
   assign epoch_seconds    = out_secs_ff;
   assign error            = out_err_ff;

`ifndef SYNTHESIS
   // A faulted item always leaves a zero count
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && err_ff |=> (out_secs_ff == '0) && out_err_ff)
      else $error("error result with non-zero seconds");
`endif

endmodule

/* hdl/cte_ctrl.sv */
`timescale 1ns / 1ps
module cte_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output cte_pkg::cte_cmd_type     cmd,
   input  cte_pkg::cte_status_type  status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_YEARS,
      S_MONTH,
      S_MULT,
      S_SUM,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Output register can take a new item when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Decode commands from state
   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == S_IDLE) && req_valid;
      cmd.year_step = (state_ff == S_YEARS) && !status.err && !status.year_done;
      cmd.add_month = (state_ff == S_MONTH);
      cmd.mult      = (state_ff == S_MULT);
      cmd.sum       = (state_ff == S_SUM);
      cmd.finish    = (state_ff == S_FINISH) && out_free;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_YEARS;
            end
         end
         S_YEARS: begin
            priority if (status.err) begin
               state_in = S_FINISH;
            end else if (status.year_done) begin
               state_in = S_MONTH;
            end
         end
         S_MONTH:  state_in = S_MULT;
         S_MULT:   state_in = S_SUM;
         S_SUM:    state_in = S_FINISH;
         S_FINISH: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // An accepted item starts the year walk
   a_accept_walk: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_YEARS)
      else $error("accepted item did not start the year walk");

   // Finishing always presents a result
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished item not presented");

   // A stalled result is never overwritten by a finishing item
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !cmd.finish)
      else $error("result overwritten while stalled");

   // The year walk keeps going until the target year is reached
   a_walk_holds: assert property (@(posedge clock) disable iff (reset)
      cmd.year_step |=> state_ff == S_YEARS)
      else $error("year walk left early");
`endif

endmodule

/* dv/calendar_to_epoch_seconds_checker.sv */
`timescale 1ns / 1ps
module calendar_to_epoch_seconds_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [cte_pkg::YEAR_W-1:0]    req_year_since_1900,
   input  logic [cte_pkg::MONTH_W-1:0]   req_month,
   input  logic [cte_pkg::DAY_W-1:0]     req_day_of_month,
   input  logic [cte_pkg::HOUR_W-1:0]    req_hour,
   input  logic [cte_pkg::MIN_W-1:0]     req_minute,
   input  logic [cte_pkg::SEC_W-1:0]     req_second,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [cte_pkg::SECS_W-1:0]    rsp_epoch_seconds,
   input  logic                          rsp_error,
   output int                            mismatch_count,
   output int                            pending_count,
   output int                            converted_count,
   output int                            rejected_count
);

   localparam int unsigned BASE_YEAR   = 1900;
   localparam int unsigned FIRST_COUNTED_YEAR = 1970;
   localparam int unsigned MONTH_COUNT = 12;
   localparam longint unsigned DAY_SECS    = 86400;
   localparam longint unsigned HOUR_SECS   = 3600;
   localparam longint unsigned MINUTE_SECS = 60;

   typedef struct packed {
      logic [cte_pkg::SECS_W-1:0] epoch_seconds;
      logic                       error;
   } epoch_result_type;

   // Conversions still owed by the block, oldest first
   epoch_result_type epoch_results_due[$];
   int               failure_tally = 0;

   assign mismatch_count = failure_tally;

   function automatic bit gregorian_leap(input int unsigned year);
      gregorian_leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
   endfunction

   function automatic int unsigned month_length(input int unsigned mon, input bit leap);
      case (mon)
         cte_pkg::MONTH_FEB: month_length = 28 + leap;
         4, 6, 9, 11:        month_length = 30;
         default:            month_length = 31;
      endcase
   endfunction

   // Work out the seconds since the epoch for one clock reading
   function automatic epoch_result_type convert_reading(
      input logic [cte_pkg::YEAR_W-1:0]  yofs,
      input logic [cte_pkg::MONTH_W-1:0] mon,
      input logic [cte_pkg::DAY_W-1:0]   day,
      input logic [cte_pkg::HOUR_W-1:0]  hr,
      input logic [cte_pkg::MIN_W-1:0]   mn,
      input logic [cte_pkg::SEC_W-1:0]   sc
   );
      epoch_result_type res;
      int unsigned      full_year;
      longint unsigned  day_total;
      longint unsigned  secs;
      res       = '0;
      full_year = BASE_YEAR + yofs;
      day_total = 0;
      if (yofs == 0 || full_year < FIRST_COUNTED_YEAR || mon < 1 || mon > MONTH_COUNT) begin
         res.error = 1'b1;
      end else begin
         for (int unsigned y = FIRST_COUNTED_YEAR; y < full_year; y++) begin
            day_total += gregorian_leap(y) ? 366 : 365;
         end
         for (int unsigned m = 1; m < mon; m++) begin
            day_total += month_length(m, gregorian_leap(full_year));
         end
         // Day zero on the first of January 1970 wraps below zero
         day_total = day_total + day - 1;
         secs = day_total * DAY_SECS + longint'(hr) * HOUR_SECS +
                longint'(mn) * MINUTE_SECS + longint'(sc);
         res.epoch_seconds = secs[cte_pkg::SECS_W-1:0];
      end
      convert_reading = res;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned want,
                                  input longint unsigned got);
      failure_tally++;
      $display("%0t: MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   // Log accepted readings, compare accepted results against the oldest one owed
   always @(posedge clock) begin : watch_channels
      epoch_result_type due;
      if (reset) begin
         epoch_results_due.delete();
         pending_count   <= 0;
         converted_count <= 0;
         rejected_count  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            epoch_results_due.push_back(convert_reading(req_year_since_1900, req_month,
               req_day_of_month, req_hour, req_minute, req_second));
         end
         if (rsp_valid && !rsp_stall) begin
            if (epoch_results_due.size() == 0) begin
               report_mismatch("result with no item outstanding, epoch_seconds", 0,
                               rsp_epoch_seconds);
            end else begin
               due = epoch_results_due.pop_front();
               if (rsp_epoch_seconds !== due.epoch_seconds) begin
                  report_mismatch("epoch_seconds", due.epoch_seconds, rsp_epoch_seconds);
               end
               if (rsp_error !== due.error) begin
                  report_mismatch("error", due.error, rsp_error);
               end
            end
            if (rsp_error === 1'b1) begin
               rejected_count <= rejected_count + 1;
            end else begin
               converted_count <= converted_count + 1;
            end
         end
         pending_count <= epoch_results_due.size();
      end
   end

endmodule

/* dv/calendar_to_epoch_seconds_tb.sv */
`timescale 1ns / 1ps
module calendar_to_epoch_seconds_tb;

   localparam int RANDOM_READINGS = 1900;
   localparam int PHASE_LENGTH    = 100;
   localparam int MAX_IDLE        = 5;
   localparam int SETTLE_CYCLES   = 200;
   localparam int QUIET_LIMIT     = 2000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [cte_pkg::YEAR_W-1:0]    req_year_since_1900 = '0;
   logic [cte_pkg::MONTH_W-1:0]   req_month = '0;
   logic [cte_pkg::DAY_W-1:0]     req_day_of_month = '0;
   logic [cte_pkg::HOUR_W-1:0]    req_hour = '0;
   logic [cte_pkg::MIN_W-1:0]     req_minute = '0;
   logic [cte_pkg::SEC_W-1:0]     req_second = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [cte_pkg::SECS_W-1:0]    rsp_epoch_seconds;
   logic                          rsp_error;

   int mismatch_count;
   int pending_count;
   int converted_count;
   int rejected_count;
   int readings_sent = 0;
   int quiet_cycles = 0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   calendar_to_epoch_seconds u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_year_since_1900 (req_year_since_1900),
      .req_month           (req_month),
      .req_day_of_month    (req_day_of_month),
      .req_hour            (req_hour),
      .req_minute          (req_minute),
      .req_second          (req_second),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_epoch_seconds   (rsp_epoch_seconds),
      .rsp_error           (rsp_error)
   );

   calendar_to_epoch_seconds_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_year_since_1900 (req_year_since_1900),
      .req_month           (req_month),
      .req_day_of_month    (req_day_of_month),
      .req_hour            (req_hour),
      .req_minute          (req_minute),
      .req_second          (req_second),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_epoch_seconds   (rsp_epoch_seconds),
      .rsp_error           (rsp_error),
      .mismatch_count      (mismatch_count),
      .pending_count       (pending_count),
      .converted_count     (converted_count),
      .rejected_count      (rejected_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Present one clock reading after an optional gap and hold it until taken
   task automatic send_reading(
      input logic [cte_pkg::YEAR_W-1:0]  yofs,
      input logic [cte_pkg::MONTH_W-1:0] mon,
      input logic [cte_pkg::DAY_W-1:0]   day,
      input logic [cte_pkg::HOUR_W-1:0]  hr,
      input logic [cte_pkg::MIN_W-1:0]   mn,
      input logic [cte_pkg::SEC_W-1:0]   sc
   );
      int gap;
      gap = req_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_year_since_1900 <= yofs;
      req_month           <= mon;
      req_day_of_month    <= day;
      req_hour            <= hr;
      req_minute          <= mn;
      req_second          <= sc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      readings_sent++;
   endtask

   // Stimulus: directed corners, random readings, then drain and verdict
   initial begin : drive_readings
      int directed_sent;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Error cases: clock not started, years before the epoch, bad months
      send_reading(8'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
      send_reading(8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
      send_reading(8'd1, 4'd6, 5'd15, 5'd12, 6'd30, 6'd30);
      send_reading(8'd69, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
      send_reading(8'd100, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0);
      send_reading(8'd100, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0);
      send_reading(8'd100, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
      // Epoch itself and the day before it, which wraps
      send_reading(8'd70, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
      send_reading(8'd70, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0);
      send_reading(8'd70, 4'd1, 5'd0, 5'd23, 6'd59, 6'd59);
      // Leap handling around February, including the centuries
      send_reading(8'd72, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0);
      send_reading(8'd72, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
      send_reading(8'd73, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
      send_reading(8'd100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
      send_reading(8'd200, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0);
      send_reading(8'd200, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
      send_reading(8'd204, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
      // Day and time of day beyond their range, added in without checks
      send_reading(8'd106, 4'd2, 5'd31, 5'd0, 6'd0, 6'd0);
      send_reading(8'd120, 4'd7, 5'd15, 5'd31, 6'd0, 6'd0);
      send_reading(8'd120, 4'd7, 5'd15, 5'd0, 6'd63, 6'd0);
      send_reading(8'd120, 4'd7, 5'd15, 5'd0, 6'd0, 6'd63);
      // Ends of the year range
      send_reading(8'd138, 4'd1, 5'd19, 5'd3, 6'd14, 6'd8);
      send_reading(8'd255, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
      send_reading(8'd255, 4'd12, 5'd31, 5'd31, 6'd63, 6'd63);
      directed_sent = readings_sent;

      // Mostly valid readings, the rest raw noise over the full field widths
      for (int i = 0; i < RANDOM_READINGS; i++) begin
         if (i % PHASE_LENGTH == 0) begin
            req_idle_on = ((i / PHASE_LENGTH) % 4) inside {0, 2};
            rsp_idle_on = ((i / PHASE_LENGTH) % 4) inside {0, 1};
         end
         if ($urandom_range(0, 9) < 8) begin
            send_reading(cte_pkg::YEAR_W'($urandom_range(70, 255)),
                         cte_pkg::MONTH_W'($urandom_range(1, 12)),
                         cte_pkg::DAY_W'($urandom_range(1, 31)),
                         cte_pkg::HOUR_W'($urandom_range(0, 23)),
                         cte_pkg::MIN_W'($urandom_range(0, 59)),
                         cte_pkg::SEC_W'($urandom_range(0, 59)));
         end else begin
            send_reading(cte_pkg::YEAR_W'($urandom), cte_pkg::MONTH_W'($urandom),
                         cte_pkg::DAY_W'($urandom), cte_pkg::HOUR_W'($urandom),
                         cte_pkg::MIN_W'($urandom), cte_pkg::SEC_W'($urandom));
         end
      end
      req_valid <= 1'b0;

      // Drain the outstanding results, then watch for strays
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Summary: %0d clock readings (%0d directed), %0d converted, %0d rejected",
               readings_sent, directed_sent, converted_count, rejected_count);
      $display("Years 1900 to 2155, months 0 to 15 and overrange times under random gaps");
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Result side: hold off each result by a random gap while result gaps are on
   initial begin : drain_results
      int hold;
      while (reset) @(posedge clock);
      forever begin
         hold = rsp_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule

/* files.f */
hdl/cte_pkg.sv
hdl/cte_dp.sv
hdl/cte_ctrl.sv
hdl/calendar_to_epoch_seconds.sv
dv/calendar_to_epoch_seconds_checker.sv
dv/calendar_to_epoch_seconds_tb.sv
